// File: rtl/core/gslqr_pkg.sv
// ============================================================================
// Gain-scheduled LQR torque package
// Shared widths, coefficient tables, item types and CSR constants.
// ============================================================================
package gslqr_pkg;

   localparam int IN_W       = 16;
   localparam int OPND_W     = IN_W + 1;
   localparam int L2_W       = 2 * IN_W;
   localparam int COEF_W     = 24;
   localparam int AL2_W      = COEF_W + L2_W + 1;
   localparam int BL_W       = COEF_W + IN_W + 1;
   localparam int ACC_W      = AL2_W + 2;
   localparam int GAIN_SHIFT = 30;
   localparam int GAIN_W     = ACC_W - GAIN_SHIFT;
   localparam int TERM_W     = GAIN_W + OPND_W + 2;
   localparam int SUM_W      = TERM_W + 4;
   localparam int TQ_SHIFT   = 20;
   localparam int ROUND_W    = SUM_W - TQ_SHIFT;
   localparam int TORQUE_W   = 24;
   localparam int NUM_TERMS  = 6;
   localparam int NUM_GAINS  = 2 * NUM_TERMS;
   localparam int NUM_STAGES = 7;

   localparam logic signed [ACC_W-1:0] GAIN_ROUND = ACC_W'(1) << (GAIN_SHIFT - 1);
   localparam logic signed [SUM_W-1:0] TQ_ROUND   = SUM_W'(1) << (TQ_SHIFT - 1);

   localparam logic signed [TORQUE_W-1:0] TORQUE_MAX = 24'sh7FFFFF;
   localparam logic signed [TORQUE_W-1:0] TORQUE_MIN = -24'sh800000;

   // Rate operands (Q5.10) are scaled by four to reach the common Q.28.
   localparam logic [NUM_TERMS-1:0] RATE_TERM_MASK = 6'b100010;

   // Leg-angle terms survive on the hip output while airborne.
   localparam int AIR_KEEP_TERMS = 2;

   // Q10.14 coefficients: rows 0..5 wheel, rows 6..11 hip.
   localparam logic signed [COEF_W-1:0] COEF_A [NUM_GAINS] = '{
      24'sd3207158,  24'sd619068,  24'sd316405,  24'sd372516,
      24'sd2193578,  24'sd348799, -24'sd3094802, -24'sd108855,
      -24'sd395115, -24'sd319957, -24'sd4971538, -24'sd687225
   };
   localparam logic signed [COEF_W-1:0] COEF_B [NUM_GAINS] = '{
      -24'sd2954822, -24'sd534190, -24'sd315050, -24'sd399525,
      -24'sd2301806, -24'sd345575,  24'sd996996, -24'sd195884,
       24'sd62038,   -24'sd118093,  24'sd3761186, 24'sd534756
   };
   localparam logic signed [COEF_W-1:0] COEF_C [NUM_GAINS] = '{
      -24'sd224184, -24'sd57863, -24'sd64224, -24'sd132170,
       24'sd885365,  24'sd136489, 24'sd481078, 24'sd189501,
       24'sd104854,  24'sd207736, 24'sd1043060, 24'sd117739
   };

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic signed [IN_W-1:0] THRESHOLD_RESET = 16'sd320;

   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic signed [TERM_W-1:0] term_type;

   typedef struct packed {
      logic        [IN_W-1:0] leg_length;
      logic signed [IN_W-1:0] leg_angle;
      logic signed [IN_W-1:0] leg_angle_rate;
      logic signed [IN_W-1:0] travel_distance;
      logic signed [IN_W-1:0] forward_speed;
      logic signed [IN_W-1:0] target_speed;
      logic signed [IN_W-1:0] body_pitch;
      logic signed [IN_W-1:0] body_pitch_rate;
      logic signed [IN_W-1:0] support_force;
   } req_item_type;

   typedef struct packed {
      logic signed [TORQUE_W-1:0] wheel_torque;
      logic signed [TORQUE_W-1:0] hip_torque;
      logic                       airborne;
   } rsp_item_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } stage_en_type;

endpackage

// File: rtl/core/gslqr_req_if.sv
// ============================================================================
// Gain-scheduled LQR request channel
// Valid/ready channel carrying one state sample item.
// ============================================================================
interface gslqr_req_if;
   import gslqr_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/gslqr_rsp_if.sv
// ============================================================================
// Gain-scheduled LQR response channel
// Valid/ready channel carrying one torque result item.
// ============================================================================
interface gslqr_rsp_if;
   import gslqr_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/gain_scheduled_lqr_torque_top.sv
// ============================================================================
// Gain-scheduled LQR torque law, top level
// Sample in, saturated wheel and hip torques out, one item per cycle if ready.
// ============================================================================
// The block accepts one state sample per clock cycle while the output side
// is ready, and returns one torque item for each sample, in order. The seven
// register stages are: input capture with operand negation and the airborne
// compare, leg length squared, the coefficient products, the rounded gains,
// the gain-by-operand terms, the masked sums, and rounding with saturation
// into the output register. Every stage carries a valid bit and advances
// whenever the stage after it is empty or moving, so bubbles are squeezed out
// and a stalled output holds its item while earlier stages keep filling. The
// support threshold is written through the APB-style port at byte address
// zero and should only be changed while no items are in flight.
module gain_scheduled_lqr_torque_top (
   input  logic                                clock,
   input  logic                                reset,
   gslqr_req_if.sink                           req_ch,
   gslqr_rsp_if.source                         rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gslqr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gslqr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gslqr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import gslqr_pkg::*;

   // ------------------------------------------------------------------
   // Configuration register. Only the index bit of the address decodes;
   // the byte offset bits are ignored.
   // ------------------------------------------------------------------
   logic signed [IN_W-1:0] threshold_ff;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1] == CSR_IDX_THRESHOLD) begin
         threshold_ff <= csr_pwdata[IN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(threshold_ff);
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. A stage may load when it is empty or when the
   // stage after it loads in the same cycle; the last stage looks at the
   // output ready.
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES:1]   valid_in;
   logic [NUM_STAGES+1:1] adv;
   stage_en_type          en;

   always_comb begin
      adv[NUM_STAGES+1] = rsp_ch.ready;
      for (int i = NUM_STAGES; i >= 1; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[1] = adv[1] ? req_ch.valid : valid_ff[1];
      for (int i = 2; i <= NUM_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4],
                 s5: adv[5], s6: adv[6], s7: adv[7]};

   assign req_ch.ready = adv[1];
   assign rsp_ch.valid = valid_ff[NUM_STAGES];

   // ------------------------------------------------------------------
   // Stage 1: capture. Operands are the negated state, widened by one bit
   // so that negating the most negative input stays exact, and the speed
   // error for the speed term.
   // ------------------------------------------------------------------
   opnd_type        opnd_in [NUM_TERMS];
   logic            air_in;
   logic [IN_W-1:0] len_ff;
   opnd_type        opnd1_ff [NUM_TERMS];
   opnd_type        opnd2_ff [NUM_TERMS];
   opnd_type        opnd3_ff [NUM_TERMS];
   opnd_type        opnd4_ff [NUM_TERMS];
   logic [5:1]      air_ff;

   always_comb begin
      opnd_in[0] = -OPND_W'(req_ch.data.leg_angle);
      opnd_in[1] = -OPND_W'(req_ch.data.leg_angle_rate);
      opnd_in[2] = -OPND_W'(req_ch.data.travel_distance);
      opnd_in[3] = OPND_W'(req_ch.data.target_speed) - OPND_W'(req_ch.data.forward_speed);
      opnd_in[4] = -OPND_W'(req_ch.data.body_pitch);
      opnd_in[5] = -OPND_W'(req_ch.data.body_pitch_rate);
      air_in     = req_ch.data.support_force < threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         len_ff    <= req_ch.data.leg_length;
         opnd1_ff  <= opnd_in;
         air_ff[1] <= air_in;
      end
      if (en.s2) begin
         opnd2_ff  <= opnd1_ff;
         air_ff[2] <= air_ff[1];
      end
      if (en.s3) begin
         opnd3_ff  <= opnd2_ff;
         air_ff[3] <= air_ff[2];
      end
      if (en.s4) begin
         opnd4_ff  <= opnd3_ff;
         air_ff[4] <= air_ff[3];
      end
      if (en.s5) begin
         air_ff[5] <= air_ff[4];
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 to 4: gains; stage 5: terms; stages 6 and 7: sums and
   // output rounding.
   // ------------------------------------------------------------------
   gain_type     gain [NUM_GAINS];
   term_type     term [NUM_GAINS];
   rsp_item_type result;

   gslqr_gain u_gain (
      .clock (clock),
      .en    (en),
      .len   (len_ff),
      .gain  (gain)
   );

   gslqr_term u_term (
      .clock (clock),
      .en    (en),
      .gain  (gain),
      .opnd  (opnd4_ff),
      .term  (term)
   );

   gslqr_sum u_sum (
      .clock  (clock),
      .en     (en),
      .term   (term),
      .air    (air_ff[5]),
      .result (result)
   );

   assign rsp_ch.data = result;

endmodule

// File: rtl/core/gslqr_gain.sv
// ============================================================================
// Gain-scheduled LQR gain scheduler
// Three stages: leg length squared, coefficient products, rounded Q.16 gains.
// ============================================================================
module gslqr_gain (
   input  logic                      clock,
   input  gslqr_pkg::stage_en_type   en,
   input  logic [gslqr_pkg::IN_W-1:0] len,
   output gslqr_pkg::gain_type       gain [gslqr_pkg::NUM_GAINS]
);
   import gslqr_pkg::*;

   logic [IN_W-1:0]  len_ff;
   logic [L2_W-1:0]  l2_ff;
   logic [L2_W-1:0]  l2_in;

   logic signed [AL2_W-1:0] al2_in [NUM_GAINS];
   logic signed [AL2_W-1:0] al2_ff [NUM_GAINS];
   logic signed [BL_W-1:0]  bl_in  [NUM_GAINS];
   logic signed [BL_W-1:0]  bl_ff  [NUM_GAINS];
   logic signed [ACC_W-1:0] acc    [NUM_GAINS];
   gain_type                gain_in [NUM_GAINS];
   gain_type                gain_ff [NUM_GAINS];

   assign l2_in = {{IN_W{1'b0}}, len} * {{IN_W{1'b0}}, len};

   always_ff @(posedge clock) begin
      if (en.s2) begin
         len_ff <= len;
         l2_ff  <= l2_in;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GAINS; g++) begin
         al2_in[g] = COEF_A[g] * $signed({1'b0, l2_ff});
         bl_in[g]  = COEF_B[g] * $signed({1'b0, len_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         al2_ff <= al2_in;
         bl_ff  <= bl_in;
      end
   end

   // a*L^2 + b*L*2^16 + c*2^32 in Q.46, rounded half up to Q.16.
   always_comb begin
      for (int g = 0; g < NUM_GAINS; g++) begin
         acc[g] = ACC_W'(al2_ff[g]) + (ACC_W'(bl_ff[g]) <<< IN_W)
                + (ACC_W'(COEF_C[g]) <<< L2_W) + GAIN_ROUND;
         gain_in[g] = GAIN_W'(acc[g] >>> GAIN_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         gain_ff <= gain_in;
      end
   end

   assign gain = gain_ff;

endmodule

// File: rtl/core/gslqr_term.sv
// ============================================================================
// Gain-scheduled LQR term multiplier
// Twelve gain-by-operand products aligned to Q.28.
// ============================================================================
module gslqr_term (
   input  logic                    clock,
   input  gslqr_pkg::stage_en_type en,
   input  gslqr_pkg::gain_type     gain [gslqr_pkg::NUM_GAINS],
   input  gslqr_pkg::opnd_type     opnd [gslqr_pkg::NUM_TERMS],
   output gslqr_pkg::term_type     term [gslqr_pkg::NUM_GAINS]
);
   import gslqr_pkg::*;

   term_type term_in [NUM_GAINS];
   term_type term_ff [NUM_GAINS];

   always_comb begin
      for (int o = 0; o < 2; o++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            term_in[o*NUM_TERMS + t] = gain[o*NUM_TERMS + t] * opnd[t];
            if (RATE_TERM_MASK[t]) begin
               term_in[o*NUM_TERMS + t] = term_in[o*NUM_TERMS + t] <<< 2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

// File: rtl/core/gslqr_sum.sv
// ============================================================================
// Gain-scheduled LQR torque summer
// Masked sums of the six terms, then rounding to Q15.8 with saturation.
// ============================================================================
module gslqr_sum (
   input  logic                    clock,
   input  gslqr_pkg::stage_en_type en,
   input  gslqr_pkg::term_type     term [gslqr_pkg::NUM_GAINS],
   input  logic                    air,
   output gslqr_pkg::rsp_item_type result
);
   import gslqr_pkg::*;

   logic signed [SUM_W-1:0]   sum_in [2];
   logic signed [SUM_W-1:0]   sum_ff [2];
   logic                      air_ff;
   logic signed [ROUND_W-1:0] rnd    [2];
   logic signed [TORQUE_W-1:0] tq_in [2];
   rsp_item_type              result_ff;

   // While airborne the wheel sum is dropped and the hip keeps only the
   // leg-angle and leg-angle-rate terms.
   always_comb begin
      sum_in[0] = '0;
      sum_in[1] = '0;
      for (int t = 0; t < NUM_TERMS; t++) begin
         if (!air) begin
            sum_in[0] = sum_in[0] + SUM_W'(term[t]);
         end
         if (!air || t < AIR_KEEP_TERMS) begin
            sum_in[1] = sum_in[1] + SUM_W'(term[NUM_TERMS + t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         sum_ff <= sum_in;
         air_ff <= air;
      end
   end

   always_comb begin
      for (int o = 0; o < 2; o++) begin
         rnd[o] = ROUND_W'((sum_ff[o] + TQ_ROUND) >>> TQ_SHIFT);
         if (rnd[o] > ROUND_W'(TORQUE_MAX)) begin
            tq_in[o] = TORQUE_MAX;
         end else if (rnd[o] < ROUND_W'(TORQUE_MIN)) begin
            tq_in[o] = TORQUE_MIN;
         end else begin
            tq_in[o] = TORQUE_W'(rnd[o]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s7) begin
         result_ff.wheel_torque <= tq_in[0];
         result_ff.hip_torque   <= tq_in[1];
         result_ff.airborne     <= air_ff;
      end
   end

   assign result = result_ff;

endmodule

// File: sim/tb.sv
// ============================================================================
// Gain-scheduled LQR torque testbench
// Drives state samples through the torque law and checks every torque item
// against an in-bench integer predictor, under several support thresholds
// and mixes of sender idling and receiver back-pressure.
// ============================================================================
module tb;
   import gslqr_pkg::*;

   // Seven register stages between sample acceptance and torque output.
   localparam int PIPE_LATENCY   = NUM_STAGES;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 275;

   // Register map: the support threshold at byte address zero. Address four
   // decodes to no register, so a write there must leave the threshold alone.
   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR     = 3'd4;

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gslqr_req_if req_ch ();
   gslqr_rsp_if rsp_ch ();

   gain_scheduled_lqr_torque_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bench copy of the threshold register and the torque items still owed
   // by the block, oldest first.
   logic signed [IN_W-1:0] cur_threshold;
   rsp_item_type           expected_torques [$];

   int error_count      = 0;
   int samples_sent     = 0;
   int torques_checked  = 0;
   int threshold_writes = 0;
   int send_idle_pct    = 0;
   int rsp_stall_pct    = 0;

   // Q10.14 gain polynomial coefficients, one row per gain: a, b, c.
   // Rows 0 to 5 feed the wheel torque, rows 6 to 11 the hip torque.
   longint gain_coef [0:11][0:2] = '{
      '{ 3207158, -2954822, -224184 },
      '{  619068,  -534190,  -57863 },
      '{  316405,  -315050,  -64224 },
      '{  372516,  -399525, -132170 },
      '{ 2193578, -2301806,  885365 },
      '{  348799,  -345575,  136489 },
      '{-3094802,   996996,  481078 },
      '{ -108855,  -195884,  189501 },
      '{ -395115,    62038,  104854 },
      '{ -319957,  -118093,  207736 },
      '{-4971538,  3761186, 1043060 },
      '{ -687225,   534756,  117739 }
   };

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The gain a*L^2 + b*L + c is exact in Q.46; it is rounded half up to Q.16.
   function automatic longint scheduled_gain(int row, longint len);
      longint acc;
      acc = gain_coef[row][0] * len * len
          + gain_coef[row][1] * len * 65536
          + gain_coef[row][2] * (longint'(1) << 32);
      return (acc + (longint'(1) << 29)) >>> 30;
   endfunction

   // Round a Q.28 sum half up to Q.8 and clamp it to 24 bits.
   function automatic logic [TORQUE_W-1:0] saturate_torque(longint sum_q28);
      longint t;
      t = (sum_q28 + (longint'(1) << 19)) >>> 20;
      if (t > 64'sd8388607) t = 64'sd8388607;
      if (t < -64'sd8388608) t = -64'sd8388608;
      return t[TORQUE_W-1:0];
   endfunction

   function automatic rsp_item_type predict_torques(req_item_type s);
      rsp_item_type r;
      longint       len;
      longint       opnd [0:5];
      longint       sum  [0:1];
      longint       scale;
      logic         air;
      len     = longint'(s.leg_length);
      air     = $signed(s.support_force) < cur_threshold;
      // Negation of the most negative value is exact at 64 bits.
      opnd[0] = -longint'($signed(s.leg_angle));
      opnd[1] = -longint'($signed(s.leg_angle_rate));
      opnd[2] = -longint'($signed(s.travel_distance));
      opnd[3] = longint'($signed(s.target_speed)) - longint'($signed(s.forward_speed));
      opnd[4] = -longint'($signed(s.body_pitch));
      opnd[5] = -longint'($signed(s.body_pitch_rate));
      sum[0]  = 0;
      sum[1]  = 0;
      for (int o = 0; o < 2; o++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            // Airborne: no wheel torque, and the hip keeps the leg-angle terms.
            if (air && (o == 0 || t >= AIR_KEEP_TERMS)) continue;
            // Rates are Q5.10 and need a factor of four to reach Q.28.
            scale = (t == 1 || t == 5) ? 4 : 1;
            sum[o] += scheduled_gain(o * NUM_TERMS + t, len) * opnd[t] * scale;
         end
      end
      r.wheel_torque = saturate_torque(sum[0]);
      r.hip_torque   = saturate_torque(sum[1]);
      r.airborne     = air;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sample construction
   // ------------------------------------------------------------------------

   function automatic logic [IN_W-1:0] small_value(int span);
      return IN_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [IN_W-1:0] clip_force(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return IN_W'(v);
   endfunction

   // Every signed state field but the support force set to one level.
   function automatic req_item_type flat_sample(logic [IN_W-1:0] len,
                                                logic [IN_W-1:0] level,
                                                logic [IN_W-1:0] support);
      req_item_type s;
      s.leg_length      = len;
      s.leg_angle       = level;
      s.leg_angle_rate  = level;
      s.travel_distance = level;
      s.forward_speed   = level;
      s.target_speed    = level;
      s.body_pitch      = level;
      s.body_pitch_rate = level;
      s.support_force   = support;
      return s;
   endfunction

   // A mix of full-range noise, samples in the normal operating envelope
   // where the torques do not saturate, and support forces near the threshold.
   function automatic req_item_type random_sample();
      req_item_type s;
      int           mode;
      mode = $urandom_range(3);
      s.leg_length      = IN_W'($urandom);
      s.leg_angle       = IN_W'($urandom);
      s.leg_angle_rate  = IN_W'($urandom);
      s.travel_distance = IN_W'($urandom);
      s.forward_speed   = IN_W'($urandom);
      s.target_speed    = IN_W'($urandom);
      s.body_pitch      = IN_W'($urandom);
      s.body_pitch_rate = IN_W'($urandom);
      s.support_force   = IN_W'($urandom);
      if (mode == 1 || mode == 3) begin
         s.leg_length      = IN_W'($urandom_range(6554, 29491));
         s.leg_angle       = small_value(2048);
         s.leg_angle_rate  = small_value(4096);
         s.travel_distance = small_value(4096);
         s.forward_speed   = small_value(4096);
         s.target_speed    = small_value(4096);
         s.body_pitch      = small_value(1024);
         s.body_pitch_rate = small_value(2048);
      end
      if (mode == 2 || mode == 3)
         s.support_force = clip_force(int'(cur_threshold) + int'($signed(small_value(4))));
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Item traffic
   // ------------------------------------------------------------------------

   // Offer one sample, with random idle cycles ahead of it, and log its
   // predicted torques at the edge where it is accepted.
   task automatic send_sample(input req_item_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_torques.push_back(predict_torques(s));
      samples_sent++;
   endtask

   // Stop offering samples and wait until every owed torque item is back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_torques.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   // Receiver: random back-pressure, and a check of every accepted item.
   initial begin
      rsp_item_type exp_item;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_torques.size() == 0) begin
               $display("%0t: torque item with none expected: wheel %0d hip %0d airborne %0b",
                        $time, rsp_ch.data.wheel_torque, rsp_ch.data.hip_torque,
                        rsp_ch.data.airborne);
               error_count++;
            end else begin
               exp_item = expected_torques.pop_front();
               torques_checked++;
               if (rsp_ch.data.wheel_torque !== exp_item.wheel_torque) begin
                  $display("%0t: wheel_torque expected %0d actual %0d", $time,
                           exp_item.wheel_torque, rsp_ch.data.wheel_torque);
                  error_count++;
               end
               if (rsp_ch.data.hip_torque !== exp_item.hip_torque) begin
                  $display("%0t: hip_torque expected %0d actual %0d", $time,
                           exp_item.hip_torque, rsp_ch.data.hip_torque);
                  error_count++;
               end
               if (rsp_ch.data.airborne !== exp_item.airborne) begin
                  $display("%0t: airborne expected %0b actual %0b", $time,
                           exp_item.airborne, rsp_ch.data.airborne);
                  error_count++;
               end
            end
         end
         if (reset)
            rsp_ch.ready <= 1'b0;
         else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a long run of cycles with no item moving on either side means
   // the block has hung.
   always @(posedge clock) begin
      int idle_cycles;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Register access
   // ------------------------------------------------------------------------

   // One APB transfer: setup cycle, access cycle, then the bus goes idle.
   // Read data is taken in the access cycle, while pready is high.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register and read the threshold back. Only the low sixteen bits
   // of the write data reach the threshold.
   task automatic write_threshold_reg(input logic [CSR_ADDR_W-1:0] addr,
                                      input logic [CSR_DATA_W-1:0] wdata);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, addr, wdata, rdata);
      if (addr == THRESHOLD_ADDR) cur_threshold = wdata[IN_W-1:0];
      threshold_writes++;
      csr_access(1'b0, THRESHOLD_ADDR, '0, rdata);
      if (rdata[IN_W-1:0] !== cur_threshold) begin
         $display("%0t: support_threshold read back expected %0d actual %0d", $time,
                  cur_threshold, $signed(rdata[IN_W-1:0]));
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extremes of every field, the negation of the most negative value, the
   // largest speed errors, and the airborne case at and around the reset
   // threshold.
   task automatic test_field_extremes();
      req_item_type s;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_sample(flat_sample(16'h0000, 16'h0000, 16'h7FFF));
      send_sample(flat_sample(16'h0000, 16'h7FFF, 16'h7FFF));
      send_sample(flat_sample(16'h0000, 16'h8000, 16'h7FFF));
      send_sample(flat_sample(16'hFFFF, 16'h7FFF, 16'h7FFF));
      send_sample(flat_sample(16'hFFFF, 16'h8000, 16'h7FFF));
      send_sample(flat_sample(16'hFFFF, 16'hFFFF, 16'h0000));
      send_sample(flat_sample(16'h8000, 16'h0001, 16'd320));
      // Largest speed errors in both directions.
      s = flat_sample(16'd13107, 16'h0000, 16'd320);
      s.forward_speed = 16'h8000;
      s.target_speed  = 16'h7FFF;
      send_sample(s);
      s.forward_speed = 16'h7FFF;
      s.target_speed  = 16'h8000;
      send_sample(s);
      // Airborne just below the reset threshold and at the bottom of range.
      send_sample(flat_sample(16'd13107, 16'h0400, 16'd319));
      send_sample(flat_sample(16'hFFFF, 16'h8000, 16'h8000));
      send_sample(flat_sample(16'h0000, 16'h7FFF, 16'h8000));
      // A leg-angle-only disturbance, once grounded and once airborne.
      s = flat_sample(16'd19661, 16'h0000, 16'd2000);
      s.leg_angle      = 16'h0800;
      s.leg_angle_rate = 16'hFC00;
      send_sample(s);
      s.support_force = 16'hFFFF;
      send_sample(s);
      // Random samples from the mixed generator.
      repeat (6) begin
         s = random_sample();
         send_sample(s);
      end
      wait_for_results();
   endtask

   // The threshold at its extremes and in between, each followed by samples
   // whose support force sits just below, at and just above it.
   task automatic test_support_threshold();
      logic signed [IN_W-1:0] levels [0:4];
      req_item_type           s;
      levels[0] = 16'sh8000;
      levels[1] = 16'sh7FFF;
      levels[2] = 16'sh0000;
      levels[3] = IN_W'($urandom);
      levels[4] = THRESHOLD_RESET;
      for (int i = 0; i < 5; i++) begin
         write_threshold_reg(THRESHOLD_ADDR, {IN_W'($urandom), levels[i]});
         for (int off = -1; off <= 1; off++) begin
            s = random_sample();
            s.support_force = clip_force(int'(cur_threshold) + off);
            send_sample(s);
         end
         send_sample(flat_sample(16'd16384, 16'h0200, 16'h8000));
         send_sample(flat_sample(16'd16384, 16'h0200, 16'h7FFF));
         wait_for_results();
      end
      // A write to an address with no register behind it changes nothing.
      write_threshold_reg(SPARE_ADDR, $urandom);
      repeat (4) begin
         s = random_sample();
         s.support_force = clip_force(int'(cur_threshold) + int'($signed(small_value(1))));
         send_sample(s);
      end
      wait_for_results();
   endtask

   // Random samples under one idling mix, at a fresh random threshold. With
   // a pause set, the sender stops halfway until every result is back.
   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input bit pause_midway);
      wait_for_results();
      write_threshold_reg(THRESHOLD_ADDR, $urandom);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (pause_midway && i == PHASE_ITEMS / 2) wait_for_results();
         send_sample(random_sample());
      end
      wait_for_results();
   endtask

   initial begin
      cur_threshold = THRESHOLD_RESET;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_support_threshold();
      test_random_phase(0, 0, 1'b0);
      test_random_phase(55, 0, 1'b1);
      test_random_phase(0, 55, 1'b0);
      test_random_phase(19, 19, 1'b0);

      wait_for_results();
      $display("Checked %0d torque items for %0d state samples over %0d register writes,",
               torques_checked, samples_sent, threshold_writes);
      $display("with sender gaps, receiver stalls, both at once, and a full drain midstream.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
